// ----- design/nvbs_pkg.sv -----
`timescale 1ns / 1ps
// nvbs_pkg: shared field widths, action codes, search states and control structs
// for the nearest-value search block. Depends on nothing.

package nvbs_pkg;

   localparam int DATA_BITS  = 32;
   localparam int INDEX_BITS = 10;
   localparam int COUNT_BITS = 11;

   localparam logic ACTION_LOAD  = 1'b0;
   localparam logic ACTION_QUERY = 1'b1;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_RD_FIRST,
      ST_CHK_FIRST,
      ST_RD_LAST,
      ST_CHK_LAST,
      ST_RD_MID,
      ST_CHK_MID,
      ST_RD_NB,
      ST_CHK_NB,
      ST_DONE
   } nvbs_state_type;

   // top level to search engine
   typedef struct packed {
      logic start;
      logic slot_free;
   } nvbs_ctrl_type;

   // search engine to top level
   typedef struct packed {
      logic busy;
      logic done;
   } nvbs_status_type;

endpackage

// ----- design/nvbs_ram.sv -----
`timescale 1ns / 1ps
// nvbs_ram: generic single-write, single-read RAM with registered read data.
// Stand-alone, no package needed.

module nvbs_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024,
   localparam int AW = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- design/nvbs_search.sv -----
`timescale 1ns / 1ps
// nvbs_search: sequencer for the nearest-entry search, with a read state and a check state per table read.
// Depends on nvbs_pkg; drives the read port of nvbs_ram.

module nvbs_search #(
   parameter int TABLE_DEPTH = 1024,
   parameter int VALUE_BITS  = 32,
   localparam int IDX_W = $clog2(TABLE_DEPTH)
) (
   input  logic                         clock,
   input  logic                         reset,
   input  nvbs_pkg::nvbs_ctrl_type      ctrl,
   input  logic signed [VALUE_BITS-1:0] query_value,
   input  logic [IDX_W-1:0]             last_index,
   output logic [IDX_W-1:0]             rd_addr,
   input  logic signed [VALUE_BITS-1:0] rd_data,
   output logic [IDX_W-1:0]             answer,
   output nvbs_pkg::nvbs_status_type    status
);

   import nvbs_pkg::*;

   nvbs_state_type state_ff, state_in;

   logic signed [VALUE_BITS-1:0] x_ff, x_in;
   logic signed [VALUE_BITS-1:0] m_ff, m_in;
   logic [IDX_W-1:0] lo_ff, lo_in;
   logic [IDX_W-1:0] hi_ff, hi_in;
   logic [IDX_W-1:0] mid_ff, mid_in;
   logic [IDX_W-1:0] nb_ff, nb_in;
   logic [IDX_W-1:0] ans_ff, ans_in;
   logic             lower_ff, lower_in;

   logic [IDX_W-1:0] mid_calc;
   logic             found;
   logic             go_mid;
   logic             go_nb;
   logic             narrow;

   // one bit wider so the differences never wrap
   logic signed [VALUE_BITS:0] x_w, d_w, m_w;
   logic signed [VALUE_BITS:0] x_minus_d, m_minus_x, d_minus_x, x_minus_m;

   assign mid_calc  = lo_ff + ((hi_ff - lo_ff) >> 1);
   assign x_w       = {x_ff[VALUE_BITS-1], x_ff};
   assign d_w       = {rd_data[VALUE_BITS-1], rd_data};
   assign m_w       = {m_ff[VALUE_BITS-1], m_ff};
   assign x_minus_d = x_w - d_w;
   assign m_minus_x = m_w - x_w;
   assign d_minus_x = d_w - x_w;
   assign x_minus_m = x_w - m_w;

   // datapath next values and decisions
   always_comb begin
      x_in     = x_ff;
      m_in     = m_ff;
      lo_in    = lo_ff;
      hi_in    = hi_ff;
      mid_in   = mid_ff;
      nb_in    = nb_ff;
      ans_in   = ans_ff;
      lower_in = lower_ff;
      found    = 1'b0;
      go_mid   = 1'b0;
      go_nb    = 1'b0;
      narrow   = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (ctrl.start) begin
               x_in   = query_value;
               lo_in  = '0;
               hi_in  = last_index;
               mid_in = '0;
            end
         end
         ST_CHK_FIRST: begin
            if (x_ff <= rd_data) begin
               ans_in = '0;
               found  = 1'b1;
            end
         end
         ST_CHK_LAST: begin
            if (x_ff >= rd_data) begin
               ans_in = last_index;
               found  = 1'b1;
            end else begin
               narrow = 1'b1;
            end
         end
         ST_RD_MID: begin
            mid_in = mid_calc;
         end
         ST_CHK_MID: begin
            m_in = rd_data;
            if (x_ff == rd_data) begin
               ans_in = mid_ff;
               found  = 1'b1;
            end else if (x_ff < rd_data) begin
               if (mid_ff != '0) begin
                  nb_in    = mid_ff - 1'b1;
                  lower_in = 1'b1;
                  go_nb    = 1'b1;
               end else begin
                  hi_in  = mid_ff;
                  narrow = 1'b1;
               end
            end else begin
               if (mid_ff < last_index) begin
                  nb_in    = mid_ff + 1'b1;
                  lower_in = 1'b0;
                  go_nb    = 1'b1;
               end else begin
                  lo_in  = mid_ff + 1'b1;
                  narrow = 1'b1;
               end
            end
         end
         ST_CHK_NB: begin
            if (lower_ff) begin
               if (x_ff > rd_data) begin
                  // tie goes to the higher index
                  ans_in = (x_minus_d < m_minus_x) ? nb_ff : mid_ff;
                  found  = 1'b1;
               end else begin
                  hi_in  = mid_ff;
                  narrow = 1'b1;
               end
            end else begin
               if (x_ff < rd_data) begin
                  ans_in = (d_minus_x > x_minus_m) ? mid_ff : nb_ff;
                  found  = 1'b1;
               end else begin
                  lo_in  = mid_ff + 1'b1;
                  narrow = 1'b1;
               end
            end
         end
         default: begin
         end
      endcase
      // narrowed range: probe again while it is open; once closed without a hit, the last probe is the answer
      if (narrow) begin
         if (lo_in < hi_in) begin
            go_mid = 1'b1;
         end else begin
            ans_in = mid_ff;
            found  = 1'b1;
         end
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (ctrl.start) begin
               state_in = ST_RD_FIRST;
            end
         end
         ST_RD_FIRST:  state_in = ST_CHK_FIRST;
         ST_CHK_FIRST: state_in = found ? ST_DONE : ST_RD_LAST;
         ST_RD_LAST:   state_in = ST_CHK_LAST;
         ST_CHK_LAST:  state_in = go_mid ? ST_RD_MID : ST_DONE;
         ST_RD_MID:    state_in = ST_CHK_MID;
         ST_CHK_MID: begin
            if (found) begin
               state_in = ST_DONE;
            end else if (go_nb) begin
               state_in = ST_RD_NB;
            end else if (go_mid) begin
               state_in = ST_RD_MID;
            end else begin
               state_in = ST_DONE;
            end
         end
         ST_RD_NB:     state_in = ST_CHK_NB;
         ST_CHK_NB:    state_in = go_mid ? ST_RD_MID : ST_DONE;
         ST_DONE: begin
            if (ctrl.slot_free) begin
               state_in = ST_IDLE;
            end
         end
         default:      state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      case (state_ff)
         ST_RD_FIRST: rd_addr = '0;
         ST_RD_LAST:  rd_addr = last_index;
         ST_RD_MID:   rd_addr = mid_calc;
         ST_RD_NB:    rd_addr = nb_ff;
         default:     rd_addr = mid_ff;
      endcase
      status.busy = (state_ff != ST_IDLE);
      status.done = (state_ff == ST_DONE) && ctrl.slot_free;
      answer      = ans_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      x_ff     <= x_in;
      m_ff     <= m_in;
      lo_ff    <= lo_in;
      hi_ff    <= hi_in;
      mid_ff   <= mid_in;
      nb_ff    <= nb_in;
      ans_ff   <= ans_in;
      lower_ff <= lower_in;
   end

endmodule

// ----- design/nearest_value_binary_search.sv -----
`timescale 1ns / 1ps
// nearest_value_binary_search: top level, table RAM, entry count register and result register.
// Depends on nvbs_pkg, nvbs_ram and nvbs_search.
//
//  channel | direction | handshake            | payload
//  req     | in        | req_valid/req_stall  | req_action, req_load_index, req_data_value
//  rsp     | out       | rsp_valid/rsp_stall  | rsp_nearest_index
//  csr     | in        | csr_wr_en            | csr_wr_data (entry count)
//
// a load word is written on acceptance; a query reads the first entry and, if needed, the last
// for the end checks, then the middle entry of each halving step, and its neighbour as well when
// needed (each read goes through the single registered RAM read port), then hands over the result.
// one item at a time: req_stall is high from a query's acceptance until its result
// moves into the output register, which may still hold an earlier result meanwhile.
// reset clears control state and sets the entry count to 1; the table needs loading.

module nearest_value_binary_search #(
   parameter int TABLE_DEPTH = 1024,
   parameter int VALUE_BITS  = 32
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  logic                                  req_action,
   input  logic [nvbs_pkg::INDEX_BITS-1:0]       req_load_index,
   input  logic signed [nvbs_pkg::DATA_BITS-1:0] req_data_value,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output logic [nvbs_pkg::INDEX_BITS-1:0]       rsp_nearest_index,
   input  logic                                  csr_wr_en,
   input  logic [nvbs_pkg::COUNT_BITS-1:0]       csr_wr_data
);

   import nvbs_pkg::*;

   localparam int IDX_W = $clog2(TABLE_DEPTH);
   localparam int CNT_W = (IDX_W + 1 > COUNT_BITS) ? IDX_W + 1 : COUNT_BITS;
   localparam int EXT_W = (VALUE_BITS > DATA_BITS) ? VALUE_BITS : DATA_BITS;

   logic [COUNT_BITS-1:0] entry_count_ff, entry_count_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [INDEX_BITS-1:0] rsp_index_ff, rsp_index_in;

   logic                         req_fire;
   logic [EXT_W-1:0]             data_ext;
   logic signed [VALUE_BITS-1:0] word_value;
   logic [CNT_W-1:0]             count_ext;
   logic [CNT_W-1:0]             load_ext;
   logic [IDX_W-1:0]             last_index;
   logic                         ram_wr_en;
   logic [IDX_W-1:0]             ram_rd_addr;
   logic signed [VALUE_BITS-1:0] ram_rd_data;
   logic [IDX_W-1:0]             search_answer;
   nvbs_ctrl_type                ctrl;
   nvbs_status_type              status;

   assign req_stall = status.busy;
   assign req_fire  = req_valid && !req_stall;

   // the word's bits taken as unsigned, then the low VALUE_BITS as two's complement
   assign data_ext   = EXT_W'($unsigned(req_data_value));
   assign word_value = data_ext[VALUE_BITS-1:0];

   assign load_ext  = CNT_W'(req_load_index);
   assign ram_wr_en = req_fire && (req_action == ACTION_LOAD)
                      && (load_ext < CNT_W'(TABLE_DEPTH));

   // entries in use, clamped to one and to the table depth
   assign count_ext = CNT_W'(entry_count_ff);
   always_comb begin
      if (count_ext == '0) begin
         last_index = '0;
      end else if (count_ext >= CNT_W'(TABLE_DEPTH)) begin
         last_index = IDX_W'(TABLE_DEPTH - 1);
      end else begin
         last_index = IDX_W'(count_ext - 1'b1);
      end
   end

   assign ctrl.start     = req_fire && (req_action == ACTION_QUERY);
   assign ctrl.slot_free = !rsp_valid_ff || !rsp_stall;

   nvbs_ram #(
      .WIDTH (VALUE_BITS),
      .DEPTH (TABLE_DEPTH)
   ) u_table (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (IDX_W'(req_load_index)),
      .wr_data (word_value),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   nvbs_search #(
      .TABLE_DEPTH (TABLE_DEPTH),
      .VALUE_BITS  (VALUE_BITS)
   ) u_search (
      .clock       (clock),
      .reset       (reset),
      .ctrl        (ctrl),
      .query_value (word_value),
      .last_index  (last_index),
      .rd_addr     (ram_rd_addr),
      .rd_data     (ram_rd_data),
      .answer      (search_answer),
      .status      (status)
   );

   always_comb begin
      entry_count_in = entry_count_ff;
      if (csr_wr_en) begin
         entry_count_in = csr_wr_data;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_index_in = rsp_index_ff;
      if (status.done) begin
         rsp_valid_in = 1'b1;
         rsp_index_in = INDEX_BITS'(search_answer);
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         entry_count_ff <= COUNT_BITS'(1);
         rsp_valid_ff   <= 1'b0;
      end else begin
         entry_count_ff <= entry_count_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_index_ff <= rsp_index_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_nearest_index = rsp_index_ff;

   // a finished search only hands over into a free result slot
   a_done_slot_free: assert property (@(posedge clock) disable iff (reset)
      status.done |-> (!rsp_valid_ff || !rsp_stall))
      else $error("search result handed over while result register was occupied");

   // the answer always lies within the entries in use
   a_answer_in_range: assert property (@(posedge clock) disable iff (reset)
      status.done |-> (search_answer <= last_index))
      else $error("search answer beyond last entry in use");

   // the engine is back to idle right after a hand-over
   a_idle_after_done: assert property (@(posedge clock) disable iff (reset)
      status.done |=> !status.busy)
      else $error("search engine still busy after hand-over");

   // an accepted query starts the engine in the next cycle
   a_start_busy: assert property (@(posedge clock) disable iff (reset)
      ctrl.start |=> status.busy)
      else $error("query accepted but search engine not started");

endmodule
